/* src/rwl_pkg.sv */
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and constants of the fair fifo reader-writer lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rwl_pkg;

  localparam int unsigned IdWidth           = 8;
  localparam int unsigned OpWidth           = 2;
  localparam int unsigned EvWidth           = 3;
  localparam int unsigned ModeWidth         = 2;
  localparam int unsigned HcWidth           = 9;
  localparam logic [HcWidth-1:0] HolderMax  = 9'd511;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdBitsDefault     = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_ACQ_READ  = 2'd0,
    OP_ACQ_WRITE = 2'd1,
    OP_REL_READ  = 2'd2,
    OP_REL_WRITE = 2'd3
  } op_e;

  typedef enum logic [EvWidth-1:0] {
    EV_GRANT    = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_WOKEN    = 3'd3,
    EV_ERROR    = 3'd4
  } event_e;

  typedef enum logic [ModeWidth-1:0] {
    MODE_FREE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

endpackage

`default_nettype wire

/* src/rwl_if.sv */
// ----------------------------------------------------------------------------
// rwl_if
// Request and result channels of the reader-writer lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

interface rwl_req_if import rwl_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OpWidth-1:0] op;
  logic [IdWidth-1:0] requester_id;

  modport source (output valid, output op, output requester_id, input ready);
  modport sink   (input valid, input op, input requester_id, output ready);
endinterface

interface rwl_res_if import rwl_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [EvWidth-1:0]   event_res;
  logic [IdWidth-1:0]   subject_id;
  logic                 granted_write;
  logic [ModeWidth-1:0] lock_mode;
  logic                 last;

  modport source (output valid, output event_res, output subject_id,
                  output granted_write, output lock_mode, output last, input ready);
  modport sink   (input valid, input event_res, input subject_id,
                  input granted_write, input lock_mode, input last, output ready);
endinterface

`default_nettype wire

/* src/rwl_cell.sv */
// ----------------------------------------------------------------------------
// rwl_cell
// One waiter slot of the queue: loads a new waiter or takes its neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_cell #(
  parameter int unsigned WIDTH = 9
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             load_i,
  input  logic [WIDTH-1:0] load_data_i,
  input  logic [WIDTH-1:0] next_data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* src/fifo_reader_writer_lock.sv */
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock
// Fair fifo reader-writer lock arbiter built on a shifting chain of waiter cells.
// ----------------------------------------------------------------------------
// Each request word gives one or more result words, the last one marked by
// last. The request is taken in the cycle the result register is free, and its
// first result shows in the next cycle. A release that hands the lock on gives
// the released word and then one woken-waiter word per cycle while the result
// register is free, one cell of the waiter chain shifting out with each word;
// at most QUEUE_DEPTH waiters are woken by one release.
// The next request is taken only after the last result of the current one.
`default_nettype none

module fifo_reader_writer_lock import rwl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned ID_BITS     = IdBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwl_req_if.sink    req_i,
  rwl_res_if.source  res_o
);

  localparam int unsigned KeepW  = (ID_BITS < IdWidth) ? ID_BITS : IdWidth;
  localparam int unsigned EntryW = KeepW + 1;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e             st_q, st_d;
  mode_e              mode_q, mode_d;
  logic [HcWidth-1:0] hc_q, hc_d, hc_rel;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               wr_drain_q, wr_drain_d;

  logic               out_valid_q, out_valid_d;
  event_e             out_ev_q, out_ev_d;
  logic [IdWidth-1:0] out_id_q, out_id_d;
  logic               out_wr_q, out_wr_d;
  mode_e              out_mode_q, out_mode_d;
  logic               out_last_q, out_last_d;

  logic               slot_free, accept, push, pop, start_drain;
  logic [KeepW-1:0]   id_keep;
  logic [EntryW-1:0]  entry_in;
  logic [EntryW-1:0]  cell_data [QUEUE_DEPTH];
  logic               head_wr, next_wr;
  logic [KeepW-1:0]   head_id;

  assign id_keep   = req_i.requester_id[KeepW-1:0];
  assign entry_in  = {req_i.op == OP_ACQ_WRITE, id_keep};
  assign head_wr   = cell_data[0][KeepW];
  assign head_id   = cell_data[0][KeepW-1:0];
  assign next_wr   = cell_data[1][KeepW];

  assign slot_free   = !out_valid_q || res_o.ready;
  assign req_i.ready = (st_q == ST_IDLE) && slot_free;
  assign accept      = req_i.valid && req_i.ready;

  // waiter chain, head at cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [EntryW-1:0] nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    rwl_cell #(.WIDTH(EntryW)) u_cell (
      .clk_i       (clk_i),
      .shift_i     (pop),
      .load_i      (push && (cnt_q[IdxW-1:0] == IdxW'(i))),
      .load_data_i (entry_in),
      .next_data_i (nbr),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    hc_d        = hc_q;
    cnt_d       = cnt_q;
    wr_drain_d  = wr_drain_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_ev_d    = out_ev_q;
    out_id_d    = out_id_q;
    out_wr_d    = out_wr_q;
    out_mode_d  = out_mode_q;
    out_last_d  = out_last_q;
    push        = 1'b0;
    pop         = 1'b0;
    start_drain = 1'b0;
    hc_rel      = (hc_q != '0) ? hc_q - HcWidth'(1) : hc_q;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_id_d    = IdWidth'(id_keep);
          out_wr_d    = 1'b0;
          out_last_d  = 1'b1;
          out_ev_d    = EV_ERROR;
          unique case (op_e'(req_i.op))
            OP_ACQ_READ: begin
              if (mode_q == MODE_FREE || (mode_q == MODE_READ && cnt_q == '0)) begin
                if (hc_q < HolderMax) begin
                  hc_d     = hc_q + HcWidth'(1);
                  mode_d   = MODE_READ;
                  out_ev_d = EV_GRANT;
                end
              end else if (cnt_q != CntW'(QUEUE_DEPTH)) begin
                push     = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
                out_ev_d = EV_QUEUED;
              end
            end
            OP_ACQ_WRITE: begin
              if (mode_q == MODE_FREE) begin
                mode_d   = MODE_WRITE;
                hc_d     = HcWidth'(1);
                out_ev_d = EV_GRANT;
                out_wr_d = 1'b1;
              end else if (cnt_q != CntW'(QUEUE_DEPTH)) begin
                push     = 1'b1;
                cnt_d    = cnt_q + CntW'(1);
                out_ev_d = EV_QUEUED;
              end
            end
            OP_REL_READ: begin
              if (mode_q == MODE_READ) begin
                out_ev_d    = EV_RELEASED;
                hc_d        = hc_rel;
                start_drain = (hc_rel == '0);
              end
            end
            OP_REL_WRITE: begin
              if (mode_q == MODE_WRITE) begin
                out_ev_d    = EV_RELEASED;
                hc_d        = '0;
                start_drain = 1'b1;
              end
            end
          endcase
          if (start_drain) begin
            if (cnt_q == '0) begin
              mode_d = MODE_FREE;
              hc_d   = '0;
            end else if (head_wr) begin
              mode_d     = MODE_WRITE;
              hc_d       = HcWidth'(1);
              wr_drain_d = 1'b1;
              st_d       = ST_DRAIN;
              out_last_d = 1'b0;
            end else begin
              mode_d     = MODE_READ;
              hc_d       = '0;
              wr_drain_d = 1'b0;
              st_d       = ST_DRAIN;
              out_last_d = 1'b0;
            end
          end
          out_mode_d = mode_d;
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = EV_WOKEN;
          out_id_d    = IdWidth'(head_id);
          out_wr_d    = head_wr;
          out_mode_d  = mode_q;
          pop         = 1'b1;
          cnt_d       = cnt_q - CntW'(1);
          if (wr_drain_q) begin
            out_last_d = 1'b1;
          end else begin
            hc_d       = hc_q + HcWidth'(1);
            out_last_d = (cnt_q == CntW'(1)) || next_wr ||
                         (hc_q >= HolderMax - HcWidth'(1));
          end
          if (out_last_d) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      mode_q      <= MODE_FREE;
      hc_q        <= '0;
      cnt_q       <= '0;
      wr_drain_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      hc_q        <= hc_d;
      cnt_q       <= cnt_d;
      wr_drain_q  <= wr_drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ev_q   <= out_ev_d;
    out_id_q   <= out_id_d;
    out_wr_q   <= out_wr_d;
    out_mode_q <= out_mode_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.event_res     = out_ev_q;
  assign res_o.subject_id    = out_id_q;
  assign res_o.granted_write = out_wr_q;
  assign res_o.lock_mode     = out_mode_q;
  assign res_o.last          = out_last_q;

endmodule

`default_nettype wire

/* src/rwl_checker.sv */
// ----------------------------------------------------------------------------
// rwl_port_checker
// Port-level checks of the reader-writer lock arbiter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_port_checker import rwl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [EvWidth-1:0]   event_res_i,
  input logic [IdWidth-1:0]   subject_id_i,
  input logic                 granted_write_i,
  input logic [ModeWidth-1:0] lock_mode_i,
  input logic                 last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({event_res_i, subject_id_i, granted_write_i, lock_mode_i, last_i}))
    else $error("result word changed while stalled");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_res_i <= EV_ERROR)
    else $error("unknown event code");

  a_write_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && granted_write_i |-> event_res_i == EV_GRANT || event_res_i == EV_WOKEN)
    else $error("write flag on a word that is no grant");

  a_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("request taken before the current one finished");

endmodule

bind fifo_reader_writer_lock rwl_port_checker u_rwl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .event_res_i     (res_o.event_res),
  .subject_id_i    (res_o.subject_id),
  .granted_write_i (res_o.granted_write),
  .lock_mode_i     (res_o.lock_mode),
  .last_i          (res_o.last)
);

`default_nettype wire
